// File: rtl/tli_pkg.sv
// Package for the table linear interpolator: row and request types, state
// encodings, result status codes and the power-up table contents.
// No dependencies; the RTL files and the result checker import it.
package tli_pkg;

	// One stored row: an ascending key and three values in tenths.
	// val[0] is the first value, val[2] the third.
	typedef struct packed {
		logic [2:0][15:0] val;
		logic [15:0]      key;
	} row_t;

	// Operands handed to the shared interpolation unit for one value lane.
	typedef struct packed {
		logic [15:0] v1;     // value at the lower bracket row
		logic [15:0] dk;     // key minus lower bracket key
		logic [15:0] den;    // bracket key span, never zero
		logic [15:0] dv_mag; // magnitude of the value step
		logic        neg;    // value step is downward
	} lerp_req_t;

	typedef enum logic [2:0] {
		STAT_INTERP    = 3'd0,
		STAT_LOW       = 3'd1,
		STAT_HIGH      = 3'd2,
		STAT_NOBRACKET = 3'd3,
		STAT_LOADED    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_CHK_FIRST,
		CS_CHK_LAST,
		CS_SCAN,
		CS_LERP_GO,
		CS_LERP_WAIT,
		CS_DONE
	} core_state_t;

	typedef enum logic [1:0] {
		LS_IDLE,
		LS_MUL,
		LS_DIV,
		LS_DONE
	} lerp_state_t;

	localparam logic [1:0] LANE_FIRST = 2'd0;
	localparam logic [1:0] LANE_LAST  = 2'd2;
	localparam logic [3:0] DIV_LAST   = 4'd15;

	localparam logic [3:0] INIT_TABLES = 4'd3;
	localparam logic [5:0] INIT_ROWS   = 6'd3;

	localparam logic [15:0] INIT_KEYS [3][3] = '{
		'{16'd10000, 16'd10500, 16'd11000},
		'{16'd10000, 16'd10500, 16'd11000},
		'{16'd10000, 16'd12000, 16'd14000}
	};

	// Each entry lists the third, second, first value so that val[0] is the first.
	localparam logic [2:0][15:0] INIT_VALS [3][3] = '{
		'{{16'd36, 16'd166, 16'd825}, {16'd38, 16'd174, 16'd875},
		  {16'd40, 16'd182, 16'd926}},
		'{{16'd32, 16'd150, 16'd750}, {16'd34, 16'd158, 16'd800},
		  {16'd36, 16'd166, 16'd850}},
		'{{16'd50, 16'd250, 16'd450}, {16'd60, 16'd280, 16'd500},
		  {16'd70, 16'd320, 16'd550}}
	};

	// Power-up content of row r of table t; rows outside the built-in tables are zero.
	function automatic row_t init_row(input logic [3:0] t, input logic [5:0] r);
		row_t row;
		row = '0;
		if (t < INIT_TABLES && r < INIT_ROWS) begin
			row.key = INIT_KEYS[t[1:0]][r[1:0]];
			row.val = INIT_VALS[t[1:0]][r[1:0]];
		end
		return row;
	endfunction

endpackage

// File: rtl/tli_row_mem.sv
// Row storage of the table linear interpolator: one write port and one
// registered read port. Depends on tli_pkg for the row type.
module tli_row_mem
	import tli_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  row_t          wdata,
	input  logic [AW-1:0] raddr,
	output row_t          rdata
);

	row_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/tli_lerp_unit.sv
// Shared interpolation unit: one 16x16 multiply, then a restoring divide one
// quotient bit per cycle, then the signed step added to v1. Depends on tli_pkg.
module tli_lerp_unit
	import tli_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  lerp_req_t   req,
	output logic        done,
	output logic [15:0] result
);

	lerp_state_t state_q, state_d;
	lerp_req_t   req_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [3:0]  cnt_q;
	logic [31:0] prod;
	logic [16:0] trial;
	logic        qbit;

	// The product is below den * 2^16, so the quotient fits in 16 bits.
	assign prod  = req_q.dk * req_q.dv_mag;
	assign trial = {rem_q, quo_q[15]};
	assign qbit  = (trial >= {1'b0, req_q.den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		result  = req_q.neg ? (req_q.v1 - quo_q) : (req_q.v1 + quo_q);
		unique case (state_q)
			LS_IDLE: begin
				if (start) state_d = LS_MUL;
			end
			LS_MUL: begin
				state_d = LS_DIV;
			end
			LS_DIV: begin
				if (cnt_q == DIV_LAST) state_d = LS_DONE;
			end
			LS_DONE: begin
				done    = 1'b1;
				state_d = LS_IDLE;
			end
			default: state_d = LS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			LS_IDLE: begin
				if (start) req_q <= req;
			end
			LS_MUL: begin
				rem_q <= prod[31:16];
				quo_q <= prod[15:0];
				cnt_q <= '0;
			end
			LS_DIV: begin
				rem_q <= qbit ? 16'(trial - {1'b0, req_q.den}) : trial[15:0];
				quo_q <= {quo_q[14:0], qbit};
				cnt_q <= cnt_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/table_linear_interpolator_core.sv
// Table linear interpolator, top level: sequencer, configuration register,
// output register. Uses tli_pkg, tli_row_mem and tli_lerp_unit.
// A load goes straight to the result; a query checks the low clamp, then the high clamp,
// then scans the rows in use for a bracket, and an interpolated query runs its three
// value lanes one after another through the shared multiply/divide unit.
// One word is worked on at a time; the next is taken in the cycle after the result enters
// the output register, so the shared divider sets the query rate.
// After reset a clearing pass writes the power-up tables into all TABLE_COUNT * MAX_ROWS
// rows of the row memory; no word is accepted until it ends.
module table_linear_interpolator_core
	import tli_pkg::*;
#(
	parameter int TABLE_COUNT = 4,
	parameter int MAX_ROWS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input words.
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata from bit 0: table_select[1:0], row_index[3:2], key_in[19:4],
	// value_a_in[35:20], value_b_in[51:36], value_c_in[67:52], zeros[71:68].
	input  logic [71:0] s_tdata,
	// tuser: mode[0] (0 load one row, 1 query).
	input  logic [0:0]  s_tuser,
	// Result words.
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata from bit 0: value_a_out[15:0], value_b_out[31:16], value_c_out[47:32].
	output logic [47:0] m_tdata,
	// tuser: result_status[2:0].
	output logic [2:0]  m_tuser,
	// rows_in_use register.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata
);

	localparam int DEPTH = TABLE_COUNT * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
	localparam int RW    = $clog2(MAX_ROWS);
	localparam logic [6:0] MAXR7 = 7'(MAX_ROWS);

	// Control state.
	core_state_t state_q, state_d;
	logic          m_valid_q, m_valid_d;
	logic [TW-1:0] clr_t_q, clr_t_d;
	logic [RW-1:0] clr_r_q, clr_r_d;
	logic [2:0]    rows_in_use_q;

	// Working registers of one query.
	logic [15:0]      key_q, key_d;
	logic [AW-1:0]    addr_q, addr_d;
	logic [AW-1:0]    last_q, last_d;
	row_t             prev_q, prev_d;
	row_t             cur_q, cur_d;
	logic [1:0]       lane_q, lane_d;
	logic [2:0][15:0] res_q, res_d;
	status_t          stat_q, stat_d;
	logic [2:0][15:0] out_q, out_d;
	status_t          out_stat_q, out_stat_d;

	// Memory and shared unit hookup.
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	row_t          mem_wdata;
	logic [AW-1:0] mem_raddr;
	row_t          rdata;
	logic          lerp_start;
	lerp_req_t     lerp_req;
	logic          lerp_done;
	logic [15:0]   lerp_result;

	// Input word fields.
	logic [1:0]    in_tsel;
	logic [1:0]    in_ridx;
	logic [15:0]   in_key;
	logic [2:0][15:0] in_vals;
	logic          ld_ok;
	logic [AW-1:0] ld_addr;
	logic [1:0]    q_tsel;
	logic [6:0]    n_sat;
	logic [AW-1:0] q_base;
	logic [AW-1:0] q_last;
	logic          hit;
	logic          clr_end;

	assign in_tsel = s_tdata[1:0];
	assign in_ridx = s_tdata[3:2];
	assign in_key  = s_tdata[19:4];
	assign in_vals = s_tdata[67:20];

	// A load outside the tables writes nothing; a query of an absent table reads table 0.
	assign ld_ok   = (32'(in_tsel) < TABLE_COUNT) && (32'(in_ridx) < MAX_ROWS);
	assign ld_addr = AW'(32'(in_tsel) * MAX_ROWS + 32'(in_ridx));
	assign q_tsel  = (32'(in_tsel) < TABLE_COUNT) ? in_tsel : 2'd0;

	// Rows in use, held to the range two through MAX_ROWS.
	always_comb begin
		n_sat = {4'd0, rows_in_use_q};
		if (n_sat < 7'd2) n_sat = 7'd2;
		if (n_sat > MAXR7) n_sat = MAXR7;
	end

	assign q_base = AW'(32'(q_tsel) * MAX_ROWS);
	assign q_last = AW'(32'(q_tsel) * MAX_ROWS + 32'(n_sat) - 32'd1);

	// The row just read brackets the key together with the row before it.
	assign hit     = (prev_q.key <= key_q) && (key_q <= rdata.key);
	assign clr_end = (clr_t_q == TW'(TABLE_COUNT - 1)) && (clr_r_q == RW'(MAX_ROWS - 1));

	assign s_tready = (state_q == CS_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_stat_q;

	// Operands for the current value lane: lower row in prev_q, upper row in cur_q.
	always_comb begin
		logic [15:0] v1;
		logic [15:0] v2;
		v1              = prev_q.val[lane_q];
		v2              = cur_q.val[lane_q];
		lerp_req.v1     = v1;
		lerp_req.dk     = key_q - prev_q.key;
		lerp_req.den    = cur_q.key - prev_q.key;
		lerp_req.neg    = (v2 < v1);
		lerp_req.dv_mag = (v2 < v1) ? (v1 - v2) : (v2 - v1);
	end

	always_comb begin
		state_d    = state_q;
		m_valid_d  = m_valid_q && !m_tready;
		clr_t_d    = clr_t_q;
		clr_r_d    = clr_r_q;
		key_d      = key_q;
		addr_d     = addr_q;
		last_d     = last_q;
		prev_d     = prev_q;
		cur_d      = cur_q;
		lane_d     = lane_q;
		res_d      = res_q;
		stat_d     = stat_q;
		out_d      = out_q;
		out_stat_d = out_stat_q;
		mem_we     = 1'b0;
		mem_waddr  = AW'(32'(clr_t_q) * MAX_ROWS + 32'(clr_r_q));
		mem_wdata  = init_row(4'(clr_t_q), 6'(clr_r_q));
		mem_raddr  = addr_q;
		lerp_start = 1'b0;

		unique case (state_q)
			CS_CLEAR: begin
				// Write the power-up tables one row per cycle.
				mem_we = 1'b1;
				if (clr_r_q == RW'(MAX_ROWS - 1)) begin
					clr_r_d = '0;
					clr_t_d = clr_t_q + TW'(1);
				end else begin
					clr_r_d = clr_r_q + RW'(1);
				end
				if (clr_end) state_d = CS_IDLE;
			end
			CS_IDLE: begin
				if (s_tvalid) begin
					key_d = in_key;
					if (!s_tuser[0]) begin
						mem_we    = ld_ok;
						mem_waddr = ld_addr;
						mem_wdata = '{val: in_vals, key: in_key};
						res_d     = '0;
						stat_d    = STAT_LOADED;
						state_d   = CS_DONE;
					end else begin
						mem_raddr = q_base;
						addr_d    = q_base;
						last_d    = q_last;
						state_d   = CS_CHK_FIRST;
					end
				end
			end
			CS_CHK_FIRST: begin
				// The low clamp is checked first, so it wins over the high clamp.
				if (key_q <= rdata.key) begin
					res_d   = rdata.val;
					stat_d  = STAT_LOW;
					state_d = CS_DONE;
				end else begin
					prev_d    = rdata;
					mem_raddr = last_q;
					state_d   = CS_CHK_LAST;
				end
			end
			CS_CHK_LAST: begin
				if (key_q >= rdata.key) begin
					res_d   = rdata.val;
					stat_d  = STAT_HIGH;
					state_d = CS_DONE;
				end else begin
					addr_d    = addr_q + AW'(1);
					mem_raddr = addr_q + AW'(1);
					state_d   = CS_SCAN;
				end
			end
			CS_SCAN: begin
				if (hit) begin
					cur_d = rdata;
					if (rdata.key == prev_q.key) begin
						// Zero span: the lower row of the pair stands as the answer.
						res_d   = prev_q.val;
						stat_d  = STAT_INTERP;
						state_d = CS_DONE;
					end else begin
						lane_d  = LANE_FIRST;
						state_d = CS_LERP_GO;
					end
				end else if (addr_q == last_q) begin
					// Keys out of order: nothing brackets the key.
					res_d   = '0;
					stat_d  = STAT_NOBRACKET;
					state_d = CS_DONE;
				end else begin
					prev_d    = rdata;
					addr_d    = addr_q + AW'(1);
					mem_raddr = addr_q + AW'(1);
				end
			end
			CS_LERP_GO: begin
				lerp_start = 1'b1;
				state_d    = CS_LERP_WAIT;
			end
			CS_LERP_WAIT: begin
				if (lerp_done) begin
					res_d[lane_q] = lerp_result;
					if (lane_q == LANE_LAST) begin
						stat_d  = STAT_INTERP;
						state_d = CS_DONE;
					end else begin
						lane_d  = lane_q + 2'd1;
						state_d = CS_LERP_GO;
					end
				end
			end
			CS_DONE: begin
				// Hand the result to the output register once it is free.
				if (!m_valid_q || m_tready) begin
					m_valid_d  = 1'b1;
					out_d      = res_q;
					out_stat_d = stat_q;
					state_d    = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= CS_CLEAR;
			m_valid_q     <= 1'b0;
			clr_t_q       <= '0;
			clr_r_q       <= '0;
			rows_in_use_q <= 3'd3;
		end else begin
			state_q   <= state_d;
			m_valid_q <= m_valid_d;
			clr_t_q   <= clr_t_d;
			clr_r_q   <= clr_r_d;
			if (cfg_we) rows_in_use_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		key_q      <= key_d;
		addr_q     <= addr_d;
		last_q     <= last_d;
		prev_q     <= prev_d;
		cur_q      <= cur_d;
		lane_q     <= lane_d;
		res_q      <= res_d;
		stat_q     <= stat_d;
		out_q      <= out_d;
		out_stat_q <= out_stat_d;
	end

	tli_row_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_row_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	tli_lerp_unit u_lerp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (lerp_start),
		.req   (lerp_req),
		.done  (lerp_done),
		.result(lerp_result)
	);

	// The row memory is written only by the clearing pass or by an accepted load word.
	a_mem_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == CS_CLEAR) || (s_tvalid && s_tready && !s_tuser[0]))
		else $error("row memory written outside clearing pass or load");

	// The scan never walks past the last row in use of the selected table.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_SCAN) |-> (addr_q <= last_q))
		else $error("row scan passed the last row in use");

	// The shared unit finishes only while the sequencer waits for it.
	a_lerp_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_done |-> (state_q == CS_LERP_WAIT))
		else $error("interpolation result arrived with no lane pending");

	// Leaving the result state always presents a word at the output.
	a_done_presents: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_DONE && state_d == CS_IDLE) |=> m_tvalid)
		else $error("result word lost on leaving the result state");

endmodule

// File: sim/lerp_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the table linear interpolator: keeps its own copy of the tables and of
// rows_in_use, predicts every result word and compares it with what the block returns.
// Depends on tli_pkg for status_t; the testbench top instantiates it beside the block.
module lerp_result_checker
	import tli_pkg::*;
#(
	parameter logic QUERY_CODE = 1'b1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	output int          error_count,
	output int          outstanding
);

	localparam int TABLES = 4;
	localparam int ROWS   = 4;

	// Power-up tables, three rows each for tables 0 to 2, listed row by row.
	localparam logic [0:8][15:0] BOOT_KEY = {16'd10000, 16'd10500, 16'd11000,
		16'd10000, 16'd10500, 16'd11000, 16'd10000, 16'd12000, 16'd14000};
	localparam logic [0:8][15:0] BOOT_A = {16'd825, 16'd875, 16'd926,
		16'd750, 16'd800, 16'd850, 16'd450, 16'd500, 16'd550};
	localparam logic [0:8][15:0] BOOT_B = {16'd166, 16'd174, 16'd182,
		16'd150, 16'd158, 16'd166, 16'd250, 16'd280, 16'd320};
	localparam logic [0:8][15:0] BOOT_C = {16'd36, 16'd38, 16'd40,
		16'd32, 16'd34, 16'd36, 16'd50, 16'd60, 16'd70};

	typedef struct packed {
		status_t     status;
		logic [15:0] val_c;
		logic [15:0] val_b;
		logic [15:0] val_a;
	} lookup_t;

	logic [15:0] row_key [TABLES*ROWS];
	logic [15:0] row_a   [TABLES*ROWS];
	logic [15:0] row_b   [TABLES*ROWS];
	logic [15:0] row_c   [TABLES*ROWS];
	logic [2:0]  rows_reg;
	lookup_t     pending_results [$];

	// One lane of v1 + (k - k1) * (v2 - v1) / (k2 - k1), quotient truncated toward zero.
	function automatic logic [15:0] lerp_lane(input logic [15:0] k, k1, k2, v1, v2);
		longint num, den, sum;
		num = (longint'(k) - longint'(k1)) * (longint'(v2) - longint'(v1));
		den = longint'(k2) - longint'(k1);
		sum = longint'(v1) + num / den;
		return sum[15:0];
	endfunction

	// Applies a load to the table copy, or works out the answer to a query.
	function automatic lookup_t predict_lookup(input logic mode, input logic [1:0] tsel,
			input logic [1:0] ridx, input logic [15:0] key, va, vb, vc);
		int      n, t, base, last, i;
		bit      found;
		lookup_t res;
		res = '0;
		if (mode != QUERY_CODE) begin
			if (tsel < TABLES && ridx < ROWS) begin
				row_key[tsel*ROWS + ridx] = key;
				row_a[tsel*ROWS + ridx]   = va;
				row_b[tsel*ROWS + ridx]   = vb;
				row_c[tsel*ROWS + ridx]   = vc;
			end
			res.status = STAT_LOADED;
			return res;
		end
		n = int'(rows_reg);
		if (n < 2) n = 2;
		if (n > ROWS) n = ROWS;
		t = (int'(tsel) >= TABLES) ? 0 : int'(tsel);
		base = t * ROWS;
		last = base + n - 1;
		if (key <= row_key[base]) begin
			res = '{STAT_LOW, row_c[base], row_b[base], row_a[base]};
		end else if (key >= row_key[last]) begin
			res = '{STAT_HIGH, row_c[last], row_b[last], row_a[last]};
		end else begin
			res.status = STAT_NOBRACKET;
			found = 1'b0;
			for (i = base; i < last; i++) begin
				if (!found && key >= row_key[i] && key <= row_key[i+1]) begin
					found = 1'b1;
					if (row_key[i] == row_key[i+1])
						res = '{STAT_INTERP, row_c[i], row_b[i], row_a[i]};
					else
						res = '{STAT_INTERP,
							lerp_lane(key, row_key[i], row_key[i+1], row_c[i], row_c[i+1]),
							lerp_lane(key, row_key[i], row_key[i+1], row_b[i], row_b[i+1]),
							lerp_lane(key, row_key[i], row_key[i+1], row_a[i], row_a[i+1])};
				end
			end
		end
		return res;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		lookup_t want;
		int      idx;
		if (!arst_n) begin
			for (idx = 0; idx < TABLES*ROWS; idx++) begin
				row_key[idx] = '0;
				row_a[idx]   = '0;
				row_b[idx]   = '0;
				row_c[idx]   = '0;
			end
			for (idx = 0; idx < 9; idx++) begin
				row_key[(idx/3)*ROWS + idx%3] = BOOT_KEY[idx];
				row_a[(idx/3)*ROWS + idx%3]   = BOOT_A[idx];
				row_b[(idx/3)*ROWS + idx%3]   = BOOT_B[idx];
				row_c[(idx/3)*ROWS + idx%3]   = BOOT_C[idx];
			end
			rows_reg = 3'd3;
			pending_results.delete();
			error_count = 0;
			outstanding = 0;
		end else begin
			// Results are retired before new words are predicted, so a stray result
			// never matches a prediction made at the same edge.
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result word with no prediction waiting: data %h status %0d",
						m_tdata, m_tuser);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("value_a_out", int'(want.val_a), int'(m_tdata[15:0]));
					check_field("value_b_out", int'(want.val_b), int'(m_tdata[31:16]));
					check_field("value_c_out", int'(want.val_c), int'(m_tdata[47:32]));
					check_field("result_status", int'(want.status), int'(m_tuser));
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(predict_lookup(s_tuser[0], s_tdata[1:0],
					s_tdata[3:2], s_tdata[19:4], s_tdata[35:20], s_tdata[51:36],
					s_tdata[67:52]));
			if (cfg_we)
				rows_reg = cfg_wdata;
			outstanding = pending_results.size();
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Testbench top for table_linear_interpolator_core: clock, reset, input words, result
// back-pressure, rows_in_use writes and the verdict. Needs tli_pkg and lerp_result_checker.
module testbench;

	// Codes carried in s_tuser.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// A correct run never goes this long without a word moving on either side. The worst
	// stretch is the long receiver hold-off plus one interpolated query.
	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORDS_PER_PHASE = 190;

	// rows_in_use for each random phase: every code once, both saturating ends included.
	localparam logic [0:7][2:0] PHASE_ROWS = {3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd7, 3'd0};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_wdata = '0;

	int error_count;
	int outstanding;
	int burst_left = 0;

	always #4 clk = ~clk;

	table_linear_interpolator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lerp_result_checker #(
		.QUERY_CODE (MODE_QUERY)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	// Offers one word and returns at the edge where it is taken. The sender works in bursts:
	// when a burst runs out, tvalid drops for a random gap before the next word goes up.
	// tvalid is only lowered and raised in different time steps.
	task automatic send_word(input logic mode, input logic [1:0] tsel, input logic [1:0] ridx,
			input logic [15:0] key, input logic [15:0] va, input logic [15:0] vb,
			input logic [15:0] vc);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, vc, vb, va, key, ridx, tsel};
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic load_row(input logic [1:0] tsel, input logic [1:0] ridx,
			input logic [15:0] key, input logic [15:0] va, input logic [15:0] vb,
			input logic [15:0] vc);
		send_word(MODE_LOAD, tsel, ridx, key, va, vb, vc);
	endtask

	// The row index and value fields of a query are don't-care, so they carry noise.
	task automatic query(input logic [1:0] tsel, input logic [15:0] key);
		send_word(MODE_QUERY, tsel, 2'($urandom), key, 16'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	// rows_in_use may only change while the block is idle. Every word yields exactly one
	// result, so once nothing is outstanding the block has finished. Outstanding is read on
	// the falling edge, away from the checker's updates.
	task automatic write_rows(input logic [2:0] value);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [15:0] random_value();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return 16'd0;
		if (pick == 1) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// Loads, 35 in 100 words, mostly keep each table ascending (row r gets a key in the r-th
	// quarter of the key range), so that most queries land between two rows; other loads use
	// arbitrary keys or keys near the power-up keys. Some queries aim at row boundaries.
	task automatic random_word();
		logic [1:0]  tsel;
		logic [1:0]  ridx;
		logic [13:0] low_bits;
		logic [15:0] key;
		int          pick;
		tsel     = 2'($urandom_range(0, 3));
		ridx     = 2'($urandom_range(0, 3));
		low_bits = 14'($urandom);
		pick     = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 35) begin
			if (pick < 75)
				key = {ridx, low_bits};
			else if (pick < 90)
				key = 16'($urandom);
			else
				key = 16'd9000 + 16'(ridx) * 16'd2000 + 16'($urandom_range(0, 999));
			load_row(tsel, ridx, key, random_value(), random_value(), random_value());
		end else begin
			if (pick < 70)
				key = 16'($urandom);
			else if (pick < 90)
				key = 16'($urandom_range(9000, 15000));
			else begin
				case ($urandom_range(0, 3))
					0: key = 16'd0;
					1: key = 16'hFFFF;
					2: key = {ridx, 14'd0};
					default: key = {ridx, 14'd0} - 16'd1;
				endcase
			end
			query(tsel, key);
		end
	endtask

	initial begin : stimulus
		int phase;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Power-up tables with three rows in use: both clamps, the exact first and last
		// keys, a key that hits a middle row exactly, and an empty table where the key
		// sits at both ends at once, so the low clamp has to win.
		query(2'd0, 16'd0);
		query(2'd0, 16'd10000);
		query(2'd0, 16'd10250);
		query(2'd0, 16'd10500);
		query(2'd0, 16'd10999);
		query(2'd0, 16'd11000);
		query(2'd1, 16'hFFFF);
		query(2'd2, 16'd13001);
		query(2'd3, 16'd0);
		query(2'd3, 16'd7);

		// A code below the legal range saturates to two rows. Table 3 gets full-scale
		// rows, with a downward step on the first and third values.
		write_rows(3'd0);
		load_row(2'd3, 2'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
		load_row(2'd3, 2'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		query(2'd3, 16'd1);
		query(2'd3, 16'd32768);
		query(2'd3, 16'hFFFE);
		query(2'd2, 16'd11000);

		// A code above the legal range saturates to four rows. Table 3 is made unsorted,
		// and table 1 gains a fourth row while table 0 keeps an empty one.
		write_rows(3'd7);
		load_row(2'd3, 2'd2, 16'd40000, 16'd1, 16'd2, 16'd3);
		load_row(2'd3, 2'd3, 16'd50000, 16'd7, 16'd8, 16'd9);
		query(2'd3, 16'd45000);
		query(2'd3, 16'd50000);
		load_row(2'd1, 2'd3, 16'd12000, 16'd900, 16'd170, 16'd40);
		query(2'd1, 16'd11500);
		query(2'd0, 16'd11500);
		write_rows(3'd4);
		query(2'd1, 16'd12000);

		for (phase = 0; phase < 8; phase++) begin
			write_rows(PHASE_ROWS[phase]);
			repeat (RANDOM_WORDS_PER_PHASE) random_word();
		end

		// Drain: wait until every prediction has been matched, then keep watching the output
		// for any stray result before the verdict.
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (80) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Result side. m_tready follows segments of random length: always ready, mostly ready,
	// or mostly stalled. Three times during the run it holds off for a long stretch while the
	// sender keeps offering, so the block fills up and has to stall its input.
	initial begin : result_sink
		int seg_left;
		int rx_mode;
		int results_seen;
		int hold_mark;
		seg_left     = 0;
		rx_mode      = 0;
		results_seen = 0;
		hold_mark    = 60;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				results_seen++;
			if (results_seen == hold_mark) begin
				// Move the mark first: no result is taken during the hold, so the count
				// is unchanged when the hold ends.
				hold_mark = results_seen + 700;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 200);
					rx_mode  = $urandom_range(0, 2);
				end
				seg_left--;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog: counts cycles in which no word moves on either side.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		do begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end while (idle_cycles < IDLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/tli_pkg.sv
rtl/tli_row_mem.sv
rtl/tli_lerp_unit.sv
rtl/table_linear_interpolator_core.sv
sim/lerp_result_checker.sv
sim/testbench.sv
